@@ sv/four_axis_pid_with_mixing_core_macros.svh @@
// ---------------------------------------------------------------------------
// Four-axis PID core assertion macros
// Clocked property wrappers, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef FOUR_AXIS_PID_WITH_MIXING_CORE_MACROS_SVH
`define FOUR_AXIS_PID_WITH_MIXING_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FAPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FAPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fapm_pkg.sv @@
// ---------------------------------------------------------------------------
// fapm_pkg
// Widths, register codes, word types and control structs of the PID core.
// ---------------------------------------------------------------------------
`default_nettype none

package fapm_pkg;

  localparam int AXES       = 4;
  localparam int DATA_W     = 16;
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int INTEG_W    = 16;
  localparam int LIM_W      = 15;
  localparam int PID_W      = 35;
  localparam int COEF_W     = 8;
  localparam int PROD_W     = 51;
  localparam int ACC_W      = 46;
  localparam int FRAC_SHIFT = 14;
  localparam int RAW_W      = ACC_W - FRAC_SHIFT;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_LO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_HI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_MAX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIM = 3'd7;

  // PID term selects
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  localparam logic [1:0] IDX_FIRST = 2'd0;
  localparam logic [1:0] IDX_LAST  = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] target_a;
    logic signed [DATA_W-1:0] target_b;
    logic signed [DATA_W-1:0] target_c;
    logic signed [DATA_W-1:0] target_d;
    logic signed [DATA_W-1:0] measured_a;
    logic signed [DATA_W-1:0] measured_b;
    logic signed [DATA_W-1:0] measured_c;
    logic signed [DATA_W-1:0] measured_d;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_a;
    logic signed [DATA_W-1:0] drive_b;
    logic signed [DATA_W-1:0] drive_c;
    logic signed [DATA_W-1:0] drive_d;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] prop;
    logic [CFG_W-1:0] integ;
    logic [CFG_W-1:0] deriv;
    logic [CFG_W-1:0] mix_lo;
    logic [CFG_W-1:0] mix_hi;
    logic [CFG_W-1:0] drv_min;
    logic [CFG_W-1:0] drv_max;
    logic [LIM_W-1:0] int_lim;
  } cfg_regs_t;

  typedef struct packed {
    logic       load;
    logic       integ;
    logic       issue;
    logic       mix;
    logic [1:0] idx_a;
    logic [1:0] idx_b;
    logic       first;
    logic       last;
    logic       clamp;
  } cmd_t;

  typedef struct packed {
    logic out_space;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/fapm_cfg.sv @@
// ---------------------------------------------------------------------------
// fapm_cfg
// Configuration register file: gains, mixing matrix, drive windows, limit.
// ---------------------------------------------------------------------------
`default_nettype none

module fapm_cfg import fapm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_regs_t            regs
);

  cfg_regs_t regs_r;

  // refuse writes while reset is held
  assign cfg_ready = rst_n;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP:    regs_r.prop    <= cfg_data;
        REG_INTEG:   regs_r.integ   <= cfg_data;
        REG_DERIV:   regs_r.deriv   <= cfg_data;
        REG_MIX_LO:  regs_r.mix_lo  <= cfg_data;
        REG_MIX_HI:  regs_r.mix_hi  <= cfg_data;
        REG_DRV_MIN: regs_r.drv_min <= cfg_data;
        REG_DRV_MAX: regs_r.drv_max <= cfg_data;
        REG_INT_LIM: regs_r.int_lim <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/fapm_ctrl.sv @@
// ---------------------------------------------------------------------------
// fapm_ctrl
// Sequencer: integral update, twelve PID products, sixteen mixing products,
// drain of the accumulate stage, clamp into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module fapm_ctrl import fapm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INTEG = 3'd1;
  localparam logic [2:0] S_PID   = 3'd2;
  localparam logic [2:0] S_MIX   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] idx_a_r, idx_a_nxt;
  logic [1:0] idx_b_r, idx_b_nxt;

  // hold the input off while busy or in reset
  assign in_stall = (state_r != S_IDLE) || !rst_n;

  always_comb begin
    state_nxt = state_r;
    idx_a_nxt = idx_a_r;
    idx_b_nxt = idx_b_r;
    cmd       = '0;
    cmd.idx_a = idx_a_r;
    cmd.idx_b = idx_b_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd.integ = 1'b1;
        idx_a_nxt = IDX_FIRST;
        idx_b_nxt = TERM_P;
        state_nxt = S_PID;
      end
      S_PID: begin
        cmd.issue = 1'b1;
        cmd.first = (idx_b_r == TERM_P);
        cmd.last  = (idx_b_r == TERM_D);
        if (idx_b_r == TERM_D) begin
          idx_b_nxt = IDX_FIRST;
          idx_a_nxt = idx_a_r + 2'd1;
          if (idx_a_r == IDX_LAST) begin
            state_nxt = S_MIX;
          end
        end else begin
          idx_b_nxt = idx_b_r + 2'd1;
        end
      end
      S_MIX: begin
        cmd.issue = 1'b1;
        cmd.mix   = 1'b1;
        cmd.first = (idx_b_r == IDX_FIRST);
        cmd.last  = (idx_b_r == IDX_LAST);
        idx_b_nxt = idx_b_r + 2'd1;
        if (idx_b_r == IDX_LAST) begin
          idx_a_nxt = idx_a_r + 2'd1;
          if (idx_a_r == IDX_LAST) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        // hold until the output register is free
        if (stat.out_space) begin
          cmd.clamp = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_a_r <= IDX_FIRST;
      idx_b_r <= IDX_FIRST;
    end else begin
      state_r <= state_nxt;
      idx_a_r <= idx_a_nxt;
      idx_b_r <= idx_b_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/fapm_dp.sv @@
// ---------------------------------------------------------------------------
// fapm_dp
// Datapath: errors, saturated integrals, one shared multiplier with a
// registered product, accumulator, drive clamps and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module fapm_dp import fapm_pkg::*; #(
  parameter int DERIV_UPDATE_PERIOD = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output stat_t     stat,
  input  in_word_t  in_data,
  input  cfg_regs_t cfg,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int TICK_W = (DERIV_UPDATE_PERIOD > 1) ? $clog2(DERIV_UPDATE_PERIOD) : 1;
  localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(DERIV_UPDATE_PERIOD - 1);

  logic signed [DATA_W-1:0]  tgt      [AXES];
  logic signed [DATA_W-1:0]  meas     [AXES];
  logic signed [ERR_W-1:0]   err_in   [AXES];
  logic signed [DIFF_W-1:0]  diff_in  [AXES];
  logic signed [DIFF_W-1:0]  int_sum  [AXES];
  logic signed [DIFF_W-1:0]  int_nxt  [AXES];
  logic signed [DIFF_W-1:0]  lim_pos, lim_neg;

  logic signed [ERR_W-1:0]   err_r    [AXES];
  logic signed [DIFF_W-1:0]  diff_r   [AXES];
  logic signed [INTEG_W-1:0] integ_r  [AXES];
  logic signed [ERR_W-1:0]   saved_r  [AXES];
  logic signed [PID_W-1:0]   pid_r    [AXES];
  logic signed [RAW_W-1:0]   mix_r    [AXES];
  logic [TICK_W-1:0]         tick_r;

  logic [CFG_W-1:0]          gain_reg, mix_reg;
  logic [2:0]                coef_sel;
  logic signed [COEF_W-1:0]  coef;
  logic signed [DATA_W-1:0]  op_a;
  logic signed [PID_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  prod_nxt, prod_r;

  logic                      acc_en_r, acc_first_r, acc_last_r, acc_mix_r;
  logic [1:0]                acc_idx_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;

  logic signed [DATA_W-1:0]  lo       [AXES];
  logic signed [DATA_W-1:0]  hi       [AXES];
  logic signed [DATA_W-1:0]  drv      [AXES];
  out_word_t                 out_r;
  logic                      out_valid_r;

  assign tgt[0]  = in_data.target_a;
  assign tgt[1]  = in_data.target_b;
  assign tgt[2]  = in_data.target_c;
  assign tgt[3]  = in_data.target_d;
  assign meas[0] = in_data.measured_a;
  assign meas[1] = in_data.measured_b;
  assign meas[2] = in_data.measured_c;
  assign meas[3] = in_data.measured_d;

  assign lim_pos = {{(DIFF_W-LIM_W){1'b0}}, cfg.int_lim};
  assign lim_neg = -lim_pos;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      err_in[i]  = {tgt[i][DATA_W-1], tgt[i]} - {meas[i][DATA_W-1], meas[i]};
      diff_in[i] = {err_in[i][ERR_W-1], err_in[i]} - {saved_r[i][ERR_W-1], saved_r[i]};
      int_sum[i] = DIFF_W'(integ_r[i]) + DIFF_W'(err_r[i]);
      if (int_sum[i] < lim_neg) begin
        int_nxt[i] = lim_neg;
      end else if (int_sum[i] > lim_pos) begin
        int_nxt[i] = lim_pos;
      end else begin
        int_nxt[i] = int_sum[i];
      end
    end
  end

  // capture errors on accept, then saturate integrals and, once every DERIV_UPDATE_PERIOD updates, save errors
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < AXES; i++) begin
        err_r[i]  <= err_in[i];
        diff_r[i] <= diff_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        integ_r[i] <= '0;
        saved_r[i] <= '0;
      end
      tick_r <= '0;
    end else if (cmd.integ) begin
      for (int i = 0; i < AXES; i++) begin
        integ_r[i] <= int_nxt[i][INTEG_W-1:0];
        if (tick_r == '0) begin
          saved_r[i] <= err_r[i];
        end
      end
      tick_r <= (tick_r == TICK_LAST) ? '0 : tick_r + 1'b1;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (cmd.idx_b)
      TERM_P:  gain_reg = cfg.prop;
      TERM_I:  gain_reg = cfg.integ;
      default: gain_reg = cfg.deriv;
    endcase
    mix_reg  = cmd.idx_a[1] ? cfg.mix_hi : cfg.mix_lo;
    coef_sel = {cmd.idx_a[0], cmd.idx_b};
    coef     = mix_reg[{coef_sel, 3'b000} +: COEF_W];
    if (cmd.mix) begin
      op_a = DATA_W'(coef);
      op_b = pid_r[cmd.idx_b];
    end else begin
      op_a = gain_reg[{cmd.idx_a, 4'b0000} +: DATA_W];
      case (cmd.idx_b)
        TERM_P:  op_b = PID_W'(err_r[cmd.idx_a]);
        TERM_I:  op_b = PID_W'(integ_r[cmd.idx_a]);
        default: op_b = PID_W'(diff_r[cmd.idx_a]);
      endcase
    end
  end

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod_r      <= prod_nxt;
      acc_first_r <= cmd.first;
      acc_last_r  <= cmd.last;
      acc_mix_r   <= cmd.mix;
      acc_idx_r   <= cmd.idx_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.issue;
    end
  end

  assign acc_nxt = (acc_first_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (acc_en_r) begin
      acc_r <= acc_nxt;
      if (acc_last_r) begin
        if (acc_mix_r) begin
          mix_r[acc_idx_r] <= RAW_W'(acc_nxt >>> FRAC_SHIFT);
        end else begin
          pid_r[acc_idx_r] <= PID_W'(acc_nxt);
        end
      end
    end
  end

  // clamp each drive to its window, lower bound tested first
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      lo[k] = cfg.drv_min[16*k +: DATA_W];
      hi[k] = cfg.drv_max[16*k +: DATA_W];
      if (mix_r[k] < RAW_W'(lo[k])) begin
        drv[k] = lo[k];
      end else if (mix_r[k] > RAW_W'(hi[k])) begin
        drv[k] = hi[k];
      end else begin
        drv[k] = mix_r[k][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      out_r.drive_a <= drv[0];
      out_r.drive_b <= drv[1];
      out_r.drive_c <= drv[2];
      out_r.drive_d <= drv[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.clamp) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign stat.out_space = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

@@ sv/four_axis_pid_with_mixing_core.sv @@
// ---------------------------------------------------------------------------
// four_axis_pid_with_mixing_core
// Words are processed one at a time: the input is stalled until the previous word
// is clamped, paced by the single shared 16x35 multiplier (28 products).
// The next word is taken while a finished result still waits on out_stall.
// Reset (rst_n low, synchronous) clears config, integrals, saved errors,
// the tick counter and all handshake state.
// ---------------------------------------------------------------------------
`default_nettype none
`include "four_axis_pid_with_mixing_core_macros.svh"

module four_axis_pid_with_mixing_core import fapm_pkg::*; #(
  parameter int DERIV_UPDATE_PERIOD = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_regs_t regs;
  cmd_t      cmd;
  stat_t     stat;

  fapm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  fapm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fapm_dp #(
    .DERIV_UPDATE_PERIOD (DERIV_UPDATE_PERIOD)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg       (regs),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `FAPM_ASSERT_NEXT(a_accept_then_integ, in_valid && !in_stall, cmd.integ, "no integral update after accept")
  `FAPM_ASSERT_NOW(a_busy_blocks_input, cmd.issue || cmd.integ || cmd.clamp, in_stall, "input open while busy")
  `FAPM_ASSERT_NEXT(a_clamp_fills_out, cmd.clamp, out_valid, "clamp did not raise out_valid")
  `FAPM_ASSERT_NOW(a_single_cmd, 1'b1, $onehot0({cmd.load, cmd.integ, cmd.issue, cmd.clamp}), "overlapping commands")

endmodule

`default_nettype wire
